// ===== src/cqwa_pkg.sv =====
// shared types and constants for the circular queue window average block
// no dependencies; imported by the controller, datapath and top level

package cqwa_pkg;

  // width of the tag, year and mean fields
  localparam int unsigned FIELD_W = 16;

  // quotient bits retired per divider cycle, and the divider step count that follows
  localparam int unsigned RADIX_BITS = 2;
  localparam int unsigned DIV_STEPS  = FIELD_W / RADIX_BITS;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  // operation codes carried on the mode field
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted item and start the ring read
    logic update;    // apply push or pop to ring, count and running sum
    logic prep;      // load the divider from the new sum and count
    logic div_step;  // retire RADIX_BITS quotient bits
  } ctrl_cmd_t;

endpackage

// ===== src/cqwa_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module cqwa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 5
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cqwa_ctrl.sv =====
// sequencing state machine for the circular queue window average block
// depends on cqwa_pkg for the command struct and divider step count

module cqwa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cqwa_pkg::ctrl_cmd_t cmd
);

  import cqwa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.update   = (state == S_UPDATE);
    cmd.prep     = (state == S_PREP);
    cmd.div_step = (state == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_UPDATE;
            in_stall <= 1'b1;
          end
        end
        S_UPDATE: begin
          state <= S_PREP;
        end
        S_PREP: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/cqwa_dp.sv =====
// datapath: ring storage, pointers, running sum and radix-4 mean divider
// depends on cqwa_pkg and cqwa_ram

module cqwa_dp #(
  parameter int unsigned DEPTH = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cqwa_pkg::ctrl_cmd_t          cmd,
  input  logic                         mode,
  input  logic [cqwa_pkg::FIELD_W-1:0] item_tag,
  input  logic [cqwa_pkg::FIELD_W-1:0] year,
  output logic                         left_valid,
  output logic [cqwa_pkg::FIELD_W-1:0] left_tag,
  output logic [cqwa_pkg::FIELD_W-1:0] left_year,
  output logic                         empty_error,
  output logic [cqwa_pkg::FIELD_W-1:0] mean_year,
  output logic [2:0]                   fill_count
);

  import cqwa_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = FIELD_W + CW;
  localparam int unsigned DW = SW + 1;

  // latched item
  logic               op_mode;
  logic [FIELD_W-1:0] op_tag;
  logic [FIELD_W-1:0] op_year;

  // ring control
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [SW-1:0] sum;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic          full;

  // ram
  logic                 ram_we;
  logic [2*FIELD_W-1:0] ram_rdata;
  logic [FIELD_W-1:0]   old_tag;
  logic [FIELD_W-1:0]   old_year;

  // divider
  logic [DW-1:0]      dvd;
  logic [CW:0]        rem;
  logic [CW:0]        dvs;
  logic [FIELD_W-1:0] low;
  logic [FIELD_W-1:0] quo;
  logic [CW:0]        rem_next;
  logic [FIELD_W-1:0] low_next;
  logic [FIELD_W-1:0] quo_next;

  logic [31:0] count_ext;

  assign full      = (count == CW'(DEPTH));
  assign head_next = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
  assign tail_next = (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
  assign ram_we    = cmd.update && (op_mode == MODE_PUSH);
  assign old_tag   = ram_rdata[2*FIELD_W-1:FIELD_W];
  assign old_year  = ram_rdata[FIELD_W-1:0];

  // read address follows head, so the oldest entry is ready in the update cycle
  cqwa_ram #(
    .WIDTH (2 * FIELD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({op_tag, op_year}),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // rounded mean is (2*sum + n) / (2*n)
  assign dvd = {sum, 1'b0} + DW'(count);

  always_comb begin
    logic [CW+1:0] trial;
    rem_next = rem;
    low_next = low;
    quo_next = quo;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial    = {rem_next, low_next[FIELD_W-1]};
      low_next = {low_next[FIELD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial    = trial - {1'b0, dvs};
        quo_next = {quo_next[FIELD_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[FIELD_W-2:0], 1'b0};
      end
      rem_next = trial[CW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (cmd.update) begin
      if (op_mode == MODE_PUSH) begin
        tail <= tail_next;
        if (full) begin
          head <= head_next;
          sum  <= sum - SW'(old_year) + SW'(op_year);
        end else begin
          count <= count + CW'(1);
          sum   <= sum + SW'(op_year);
        end
      end else if (count != '0) begin
        head  <= head_next;
        count <= count - CW'(1);
        sum   <= sum - SW'(old_year);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode <= mode;
      op_tag  <= item_tag;
      op_year <= year;
    end
    if (cmd.update) begin
      // evicted or popped entry, zero when nothing leaves
      if ((op_mode == MODE_PUSH && full) || (op_mode == MODE_POP && count != '0)) begin
        left_valid <= 1'b1;
        left_tag   <= old_tag;
        left_year  <= old_year;
      end else begin
        left_valid <= 1'b0;
        left_tag   <= '0;
        left_year  <= '0;
      end
      empty_error <= (op_mode == MODE_POP) && (count == '0);
    end
    if (cmd.prep) begin
      // top bits of the dividend are below the divisor since the mean fits 16 bits
      rem <= dvd[DW-1:FIELD_W];
      low <= dvd[FIELD_W-1:0];
      dvs <= {count, 1'b0};
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      low <= low_next;
      quo <= quo_next;
    end
  end

  assign mean_year  = (count == '0) ? '0 : quo;
  assign count_ext  = 32'(count);
  assign fill_count = count_ext[2:0];

endmodule

// ===== src/circular_queue_window_average.sv =====
// top level of the circular queue window average block
// depends on cqwa_pkg, cqwa_ctrl, cqwa_dp (and cqwa_ram through the datapath)

// usage
// - input channel (in_valid / in_stall) carries one item: mode, item_tag, year
//   mode push stores the item, evicting and reporting the oldest entry when full;
//   mode pop removes and reports the oldest entry, or flags empty_error if empty
// - output channel (out_valid / out_stall) carries one result item per input item:
//   left_valid/left_tag/left_year, empty_error, mean_year and fill_count
// - sequence: after acceptance the ring update state, the divider load state and the
//   divider states at two quotient bits each run in order before out_valid rises;
//   the ram read of the oldest entry overlaps the accepting edge
// - one item at a time: the next item is taken only after the result has been taken
//   and the block has gone back to idle;
//   this limit is set by the shared mean divider, which also needs the fresh sum
// - in_stall is high from acceptance until the result has been taken
// - a receiver stall holds the result and every output field stable; the block
//   takes no new item until out_valid and !out_stall coincide
// - reset (rst, synchronous) empties the queue: pointers, count and running sum go
//   to zero, the ring contents are left as they are and are never read unwritten
// - mean_year is the running sum over the count rounded half up, 0 when empty

module circular_queue_window_average #(
  parameter int unsigned DEPTH = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [cqwa_pkg::FIELD_W-1:0] item_tag,
  input  logic [cqwa_pkg::FIELD_W-1:0] year,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         left_valid,
  output logic [cqwa_pkg::FIELD_W-1:0] left_tag,
  output logic [cqwa_pkg::FIELD_W-1:0] left_year,
  output logic                         empty_error,
  output logic [cqwa_pkg::FIELD_W-1:0] mean_year,
  output logic [2:0]                   fill_count
);

  import cqwa_pkg::*;

  // command bundle from the sequencer to the datapath
  ctrl_cmd_t cmd;

  // sequencer: handshakes and the update / divide schedule
  cqwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: ring ram, pointers, running sum, mean divider and result registers
  cqwa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .item_tag    (item_tag),
    .year        (year),
    .left_valid  (left_valid),
    .left_tag    (left_tag),
    .left_year   (left_year),
    .empty_error (empty_error),
    .mean_year   (mean_year),
    .fill_count  (fill_count)
  );

endmodule

// ===== src/cqwa_checker.sv =====
// port-level checks for the circular queue window average block
// depends on cqwa_pkg; bound to the top level at the end of this file

module cqwa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         mode,
  input logic [cqwa_pkg::FIELD_W-1:0] item_tag,
  input logic [cqwa_pkg::FIELD_W-1:0] year,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         left_valid,
  input logic [cqwa_pkg::FIELD_W-1:0] left_tag,
  input logic [cqwa_pkg::FIELD_W-1:0] left_year,
  input logic                         empty_error,
  input logic [cqwa_pkg::FIELD_W-1:0] mean_year,
  input logic [2:0]                   fill_count
);

  import cqwa_pkg::*;

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_tag) && $stable(left_year)
      && $stable(mean_year) && $stable(fill_count))
    else $error("stalled result changed");

  // a failed pop reports nothing leaving and an empty queue
  assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_error |-> !left_valid && left_tag == '0 && left_year == '0
      && mean_year == '0 && fill_count == '0)
    else $error("empty pop result not clean");

  // one item in flight: no item is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while result pending");

  // a result never appears the cycle after an item is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("result too early after acceptance");

  // a nonzero mean needs a nonempty queue or a pop that did not fail
  assert property (@(posedge clk) disable iff (rst)
    out_valid && mean_year != '0 |-> fill_count != '0 || !empty_error)
    else $error("mean reported on failed pop");

endmodule

bind circular_queue_window_average cqwa_checker u_cqwa_checker (.*);
